// ----- design/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types and constants of the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int MAX_HEAP_BYTES = 32768;
	localparam int GRANULE_BYTES  = 8;
	localparam int SLOT_COUNT     = MAX_HEAP_BYTES / GRANULE_BYTES;
	localparam int GW             = $clog2(SLOT_COUNT);
	localparam int HEAP_MIN_BYTES = 64;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OOS  = 2'd1;
	localparam logic [1:0] ST_NULL = 2'd2;
	localparam logic [1:0] ST_BAD  = 2'd3;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic [GW-1:0] RESET_END = GW'((MAX_HEAP_BYTES - GRANULE_BYTES) / GRANULE_BYTES);

	typedef struct packed {
		logic          used;
		logic [GW-1:0] link;
		logic [GW-1:0] size;
	} hdr_t;

	typedef struct packed {
		logic          we;
		logic [GW-1:0] waddr;
		hdr_t          wdata;
		logic [GW-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic        action;
		logic [15:0] request_bytes;
		logic [14:0] block_offset;
	} in_item_t;

	typedef struct packed {
		logic [14:0] result_offset;
		logic [1:0]  status;
		logic [15:0] free_bytes;
		logic [15:0] low_water_bytes;
	} out_item_t;

	typedef struct packed {
		logic          start;
		in_item_t      item;
		logic          fmt;
		logic [GW-1:0] fmt_end;
	} seq_cmd_t;

	typedef struct packed {
		logic      idle;
		logic      done;
		out_item_t item;
	} seq_rsp_t;

endpackage

// ----- design/first_fit_heap_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// first-fit allocator of heap block headers with coalescing on free
// ----------------------------------------------------------------------------
//  channel | signals                       | moves
//  req     | req_valid req_ready req_data  | one allocate or free transaction
//  rsp     | rsp_valid rsp_ready rsp_data  | one result per request
//  cfg     | cfg_valid cfg_ready cfg_data  | heap size in bytes
//
// an allocate walks the free list from the head for the first block that fits
// and walks it again to insert the rest of a split block; a free walks it
// to insert the freed block; all walks share the single header store read port
// reset and every cfg write run a clearing pass over every slot of the store
// requests wait during the pass, while one runs and while a result is unread
// cfg_ready stays high; a write restarts the clearing pass
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ffha_pkg::in_item_t  req_data,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ffha_pkg::out_item_t rsp_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);
	import ffha_pkg::*;

	// clearing pass control
	logic          clr_busy_q;
	logic [GW-1:0] clr_cnt_q;
	logic [GW-1:0] end_q;

	seq_cmd_t cmd;
	seq_rsp_t srsp;
	mem_req_t seq_mreq, mreq;
	hdr_t     rdata;
	logic     rsp_valid_q;

	logic        cfg_fire;
	logic [15:0] heap_clamped;
	logic [15:0] heap_less;
	logic [GW-1:0] new_end;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// clamp the written size into the legal range
	always_comb begin
		priority if (cfg_data < 16'(HEAP_MIN_BYTES)) begin
			heap_clamped = 16'(HEAP_MIN_BYTES);
		end else if (cfg_data > 16'(MAX_HEAP_BYTES)) begin
			heap_clamped = 16'(MAX_HEAP_BYTES);
		end else begin
			heap_clamped = cfg_data;
		end
	end
	assign heap_less = heap_clamped - 16'(GRANULE_BYTES);
	assign new_end   = heap_less[GW+2:3];

	// a request waits for a formatted store, an idle sequencer and an empty result slot
	assign req_ready = !clr_busy_q && srsp.idle && !rsp_valid_q;

	assign cmd.start   = req_valid && req_ready;
	assign cmd.item    = req_data;
	assign cmd.fmt     = cfg_fire;
	assign cmd.fmt_end = new_end;

	// store port: the clearing pass owns it while busy
	always_comb begin
		if (clr_busy_q) begin
			mreq.we    = 1'b1;
			mreq.waddr = clr_cnt_q;
			mreq.raddr = '0;
			if (clr_cnt_q == '0) begin
				mreq.wdata = '{used: 1'b0, link: end_q, size: end_q};
			end else begin
				mreq.wdata = '0;
			end
		end else begin
			mreq = seq_mreq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			end_q      <= RESET_END;
		end else if (cfg_fire) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			end_q      <= new_end;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + GW'(1);
			if (clr_cnt_q == GW'(SLOT_COUNT - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// result register, loaded when the sequencer finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (srsp.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (srsp.done) begin
			rsp_data <= srsp.item;
		end
	end

	assign rsp_valid = rsp_valid_q;

	ffha_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (srsp),
		.mreq   (seq_mreq),
		.rdata  (rdata)
	);

	ffha_hdr_ram u_ram (
		.clk   (clk),
		.req   (mreq),
		.rdata (rdata)
	);

`ifndef SYNTHESIS
	// the sequencer never finishes while the result slot is still full
	a_done_slot: assert property (@(posedge clk) disable iff (!arst_n)
		srsp.done |-> !rsp_valid_q)
		else $error("result produced while slot occupied");

	// a cfg write always starts a clearing pass
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_fire |=> clr_busy_q && clr_cnt_q == '0)
		else $error("cfg write did not restart clearing");

	// a new result only appears after the sequencer finished
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(srsp.done))
		else $error("result without finished request");
`endif

endmodule

// ----- design/ffha_hdr_ram.sv -----
// ----------------------------------------------------------------------------
// ffha_hdr_ram
// header store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ffha_hdr_ram (
	input  logic              clk,
	input  ffha_pkg::mem_req_t req,
	output ffha_pkg::hdr_t    rdata
);
	import ffha_pkg::*;

	hdr_t mem_q [SLOT_COUNT];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata <= mem_q[req.raddr];
	end

endmodule

// ----- design/ffha_seq.sv -----
// ----------------------------------------------------------------------------
// ffha_seq
// sequencer for allocate, free and list insertion with coalescing
// ----------------------------------------------------------------------------
module ffha_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  ffha_pkg::seq_cmd_t cmd,
	output ffha_pkg::seq_rsp_t rsp,
	output ffha_pkg::mem_req_t mreq,
	input  ffha_pkg::hdr_t     rdata
);
	import ffha_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE  = 15'h0001,
		S_A_RD  = 15'h0002,
		S_A_CHK = 15'h0004,
		S_A_UNL = 15'h0008,
		S_A_CUR = 15'h0010,
		S_F_CHK = 15'h0020,
		S_I_CMP = 15'h0040,
		S_I_ADV = 15'h0080,
		S_I_NX  = 15'h0100,
		S_I_MG  = 15'h0200,
		S_I_W1  = 15'h0400,
		S_I_W2  = 15'h0800,
		S_I_W3  = 15'h1000,
		S_I_W4  = 15'h2000,
		S_DONE  = 15'h4000
	} state_t;

	state_t        st_q;
	logic [GW-1:0] head_q, sent_q;
	logic [15:0]   rem_q, lw_q;
	logic [1:0]    status_q;
	logic [14:0]   res_q;
	logic [GW-1:0] cur_q, cur_size_q, cur_link_q, ng_q;
	logic          prev_head_q;
	logic [GW-1:0] prev_q;
	hdr_t          ph_q;
	logic [GW-1:0] nb_q, nb_size_q, nx_q;
	hdr_t          nxh_q;
	logic          pm_q, nm_q;
	logic [GW-1:0] nb2_q, s3_q, link3_q;

	// combinational helpers
	logic [16:0]   need;
	logic [GW-1:0] g;
	logic [GW-1:0] rest;
	logic          split;
	logic [GW-1:0] size_fin;
	logic [15:0]   rem_alloc;
	logic          pm, nm;
	logic [GW-1:0] nb2, s2;

	assign need      = (17'(cmd.item.request_bytes) + 17'd15) & ~17'd7;
	assign g         = cmd.item.block_offset[14:3] - GW'(1);
	assign rest      = cur_size_q - ng_q;
	assign split     = rest > GW'(2);
	assign size_fin  = split ? ng_q : cur_size_q;
	assign rem_alloc = rem_q - {1'b0, size_fin, 3'b000};
	assign pm        = !prev_head_q && (({1'b0, prev_q} + {1'b0, ph_q.size}) == {1'b0, nb_q});
	assign nb2       = pm ? prev_q : nb_q;
	assign s2        = pm ? (ph_q.size + nb_size_q) : nb_size_q;
	assign nm        = (({1'b0, nb2} + {1'b0, s2}) == {1'b0, nx_q}) && (nx_q != sent_q);

	always_comb begin
		mreq = '0;
		unique case (st_q)
			S_IDLE:  mreq.raddr = g;
			S_A_RD:  mreq.raddr = cur_q;
			S_I_CMP: mreq.raddr = nx_q;
			S_A_UNL: begin
				mreq.we    = !prev_head_q;
				mreq.waddr = prev_q;
				mreq.wdata = '{used: ph_q.used, link: cur_link_q, size: ph_q.size};
			end
			S_A_CUR: begin
				mreq.we    = 1'b1;
				mreq.waddr = cur_q;
				mreq.wdata = '{used: 1'b1, link: '0, size: size_fin};
			end
			S_I_W1: begin
				mreq.we    = pm_q;
				mreq.waddr = nb_q;
			end
			S_I_W2: begin
				mreq.we    = nm_q;
				mreq.waddr = nx_q;
			end
			S_I_W3: begin
				mreq.we    = 1'b1;
				mreq.waddr = nb2_q;
				mreq.wdata = '{used: 1'b0, link: link3_q, size: s3_q};
			end
			S_I_W4: begin
				mreq.we    = !pm_q && !prev_head_q;
				mreq.waddr = prev_q;
				mreq.wdata = '{used: ph_q.used, link: nb2_q, size: ph_q.size};
			end
			default: mreq = '0;
		endcase
	end

	assign rsp.idle = (st_q == S_IDLE);
	assign rsp.done = (st_q == S_DONE);
	assign rsp.item = '{result_offset: res_q, status: status_q,
		free_bytes: rem_q, low_water_bytes: lw_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			head_q   <= '0;
			sent_q   <= RESET_END;
			rem_q    <= {1'b0, RESET_END, 3'b000};
			lw_q     <= {1'b0, RESET_END, 3'b000};
			status_q <= ST_OK;
			res_q    <= '0;
		end else if (cmd.fmt) begin
			st_q   <= S_IDLE;
			head_q <= '0;
			sent_q <= cmd.fmt_end;
			rem_q  <= {1'b0, cmd.fmt_end, 3'b000};
			lw_q   <= {1'b0, cmd.fmt_end, 3'b000};
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (cmd.start) begin
						res_q    <= '0;
						status_q <= ST_OK;
						if (cmd.item.action == ACT_ALLOC) begin
							if (cmd.item.request_bytes == 16'd0) begin
								status_q <= ST_BAD;
								st_q     <= S_DONE;
							end else if (need > {1'b0, rem_q}) begin
								status_q <= ST_OOS;
								st_q     <= S_DONE;
							end else begin
								ng_q        <= need[GW+2:3];
								cur_q       <= head_q;
								prev_head_q <= 1'b1;
								st_q        <= S_A_RD;
							end
						end else begin
							if (cmd.item.block_offset == 15'd0) begin
								status_q <= ST_NULL;
								st_q     <= S_DONE;
							end else if (cmd.item.block_offset[2:0] != 3'd0 || g >= sent_q) begin
								status_q <= ST_BAD;
								st_q     <= S_DONE;
							end else begin
								nb_q <= g;
								st_q <= S_F_CHK;
							end
						end
					end
				end
				S_A_RD: st_q <= S_A_CHK;
				S_A_CHK: begin
					if (rdata.size < ng_q && cur_q != sent_q) begin
						prev_q      <= cur_q;
						prev_head_q <= 1'b0;
						ph_q        <= rdata;
						cur_q       <= rdata.link;
						st_q        <= S_A_RD;
					end else if (cur_q == sent_q || rdata.size < ng_q) begin
						status_q <= ST_OOS;
						st_q     <= S_DONE;
					end else begin
						cur_size_q <= rdata.size;
						cur_link_q <= rdata.link;
						st_q       <= S_A_UNL;
					end
				end
				S_A_UNL: begin
					if (prev_head_q) begin
						head_q <= cur_link_q;
					end
					st_q <= S_A_CUR;
				end
				S_A_CUR: begin
					rem_q <= rem_alloc;
					if (rem_alloc < lw_q) begin
						lw_q <= rem_alloc;
					end
					res_q <= {cur_q + GW'(1), 3'b000};
					if (split) begin
						nb_q        <= cur_q + ng_q;
						nb_size_q   <= rest;
						prev_head_q <= 1'b1;
						nx_q        <= head_q;
						st_q        <= S_I_CMP;
					end else begin
						st_q <= S_DONE;
					end
				end
				S_F_CHK: begin
					if (!rdata.used) begin
						status_q <= ST_BAD;
						st_q     <= S_DONE;
					end else begin
						nb_size_q   <= rdata.size;
						rem_q       <= rem_q + {1'b0, rdata.size, 3'b000};
						prev_head_q <= 1'b1;
						nx_q        <= head_q;
						st_q        <= S_I_CMP;
					end
				end
				S_I_CMP: st_q <= (nx_q < nb_q) ? S_I_ADV : S_I_NX;
				S_I_ADV: begin
					prev_q      <= nx_q;
					prev_head_q <= 1'b0;
					ph_q        <= rdata;
					nx_q        <= rdata.link;
					st_q        <= S_I_CMP;
				end
				S_I_NX: begin
					nxh_q <= rdata;
					st_q  <= S_I_MG;
				end
				S_I_MG: begin
					pm_q    <= pm;
					nm_q    <= nm;
					nb2_q   <= nb2;
					s3_q    <= nm ? (s2 + nxh_q.size) : s2;
					link3_q <= nm ? nxh_q.link : nx_q;
					st_q    <= S_I_W1;
				end
				S_I_W1: st_q <= S_I_W2;
				S_I_W2: st_q <= S_I_W3;
				S_I_W3: st_q <= S_I_W4;
				S_I_W4: begin
					if (!pm_q && prev_head_q) begin
						head_q <= nb2_q;
					end
					st_q <= S_DONE;
				end
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule
